// ===== rtl/opu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opu_pkg
// Shared constants and codes for the order price by urgency block.
// ----------------------------------------------------------------------------
package opu_pkg;

  localparam int OPU_PRICE_BITS = 48;
  localparam int OPU_TICK_BITS  = 32;
  localparam int OPU_OFF_BITS   = 16;
  // offset times tick always fits here
  localparam int OPU_DELTA_BITS = OPU_OFF_BITS + OPU_TICK_BITS;
  // half sum bits resolved per divider stage
  localparam int OPU_DIV_STEP   = 4;

  typedef enum logic [1:0] {
    URG_MAKER     = 2'd0,
    URG_MAKER_ONE = 2'd1,
    URG_MIDPOINT  = 2'd2,
    URG_TAKER     = 2'd3
  } urg_t;

  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2
  } op_t;

endpackage

// ===== rtl/opu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opu interfaces
// Quote request, price result and tick size write channels.
// ----------------------------------------------------------------------------
interface opu_quote_if #(parameter int PRICE_BITS = opu_pkg::OPU_PRICE_BITS);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] bid_price;
  logic [PRICE_BITS-1:0] ask_price;
  logic                  side;
  logic [1:0]            urgency;
  logic [15:0]           tick_offset;
  modport source (output valid, bid_price, ask_price, side, urgency, tick_offset,
                  input ready);
  modport sink   (input valid, bid_price, ask_price, side, urgency, tick_offset,
                  output ready);
endinterface

interface opu_result_if #(parameter int PRICE_BITS = opu_pkg::OPU_PRICE_BITS);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;
  logic                  range_flag;
  modport source (output valid, price, range_flag, input ready);
  modport sink   (input valid, price, range_flag, output ready);
endinterface

interface opu_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] tick_size;
  modport source (output valid, tick_size, input ready);
  modport sink   (input valid, tick_size, output ready);
endinterface

// ===== rtl/opu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opu_front
// Tick register, input capture, offset product, half sum and spread check.
// ----------------------------------------------------------------------------
module opu_front #(
  parameter int PRICE_BITS = opu_pkg::OPU_PRICE_BITS,
  parameter int HW         = PRICE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  opu_quote_if.sink                           quote,
  opu_cfg_if.sink                             cfg,
  output logic                                v,
  output logic [PRICE_BITS-1:0]               bid,
  output logic [PRICE_BITS-1:0]               ask,
  output logic                                side,
  output logic [1:0]                          urg,
  output logic [opu_pkg::OPU_TICK_BITS-1:0]   tick,
  output logic [opu_pkg::OPU_DELTA_BITS-1:0]  delta,
  output logic [HW-1:0]                       half,
  output logic                                odd,
  output logic                                one_tick
);
  import opu_pkg::*;

  localparam int CW = (PRICE_BITS > OPU_TICK_BITS) ? PRICE_BITS : OPU_TICK_BITS;

  logic [OPU_TICK_BITS-1:0]  tick_reg;
  logic                      a_v;
  logic [PRICE_BITS-1:0]     a_bid;
  logic [PRICE_BITS-1:0]     a_ask;
  logic                      a_side;
  logic [1:0]                a_urg;
  logic [OPU_OFF_BITS-1:0]   a_off;
  logic [OPU_TICK_BITS-1:0]  a_tick;
  logic [PRICE_BITS:0]       sum;
  logic [PRICE_BITS-1:0]     diff;
  logic [OPU_DELTA_BITS-1:0] prod;

  assign cfg.ready   = 1'b1;
  assign quote.ready = en;

  // tick size register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_reg <= OPU_TICK_BITS'(1);
    end else if (cfg.valid) begin
      tick_reg <= cfg.tick_size;
    end
  end

  // capture stage, zero tick taken as one
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= quote.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_bid  <= quote.bid_price;
      a_ask  <= quote.ask_price;
      a_side <= quote.side;
      a_urg  <= quote.urgency;
      a_off  <= quote.tick_offset;
      a_tick <= (tick_reg == '0) ? OPU_TICK_BITS'(1) : tick_reg;
    end
  end

  // offset product, quote sum and spread difference
  always_comb begin
    prod = OPU_DELTA_BITS'(a_off) * OPU_DELTA_BITS'(a_tick);
    sum  = {1'b0, a_bid} + {1'b0, a_ask};
    diff = a_ask - a_bid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bid      <= a_bid;
      ask      <= a_ask;
      side     <= a_side;
      urg      <= a_urg;
      tick     <= a_tick;
      delta    <= prod;
      half     <= HW'(sum[PRICE_BITS:1]);
      odd      <= sum[0];
      one_tick <= (a_ask >= a_bid) && (CW'(diff) == CW'(a_tick));
    end
  end

endmodule

// ===== rtl/opu_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opu_div_stage
// One stage of the restoring remainder chain: half sum modulo tick.
// ----------------------------------------------------------------------------
module opu_div_stage #(
  parameter int HW    = opu_pkg::OPU_PRICE_BITS,
  parameter int LEVEL = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              v_i,
  input  logic [HW-1:0]                     half_i,
  input  logic [opu_pkg::OPU_TICK_BITS-1:0] tick,
  input  logic [opu_pkg::OPU_TICK_BITS-1:0] rem_i,
  output logic                              v_o,
  output logic [HW-1:0]                     half_o,
  output logic [opu_pkg::OPU_TICK_BITS-1:0] rem_o
);
  import opu_pkg::*;

  logic [OPU_TICK_BITS-1:0] r;
  logic [OPU_TICK_BITS:0]   t;

  // shift in one dividend bit per step, subtract when it fits
  always_comb begin
    r = rem_i;
    t = '0;
    for (int j = 0; j < OPU_DIV_STEP; j++) begin
      t = {r, half_i[HW-1-LEVEL*OPU_DIV_STEP-j]};
      if (t >= {1'b0, tick}) begin
        t = t - {1'b0, tick};
      end
      r = t[OPU_TICK_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      half_o <= half_i;
      rem_o  <= r;
    end
  end

endmodule

// ===== rtl/opu_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opu_select
// Picks base price, step and operation for the urgency mode and side.
// ----------------------------------------------------------------------------
module opu_select #(
  parameter int PRICE_BITS = opu_pkg::OPU_PRICE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               v_i,
  input  logic [PRICE_BITS-1:0]              bid,
  input  logic [PRICE_BITS-1:0]              ask,
  input  logic                               side,
  input  logic [1:0]                         urg,
  input  logic [opu_pkg::OPU_TICK_BITS-1:0]  tick,
  input  logic [opu_pkg::OPU_DELTA_BITS-1:0] delta,
  input  logic [PRICE_BITS-1:0]              half,
  input  logic                               odd,
  input  logic                               one_tick,
  input  logic [opu_pkg::OPU_TICK_BITS-1:0]  rem,
  output logic                               v_o,
  output logic [PRICE_BITS-1:0]              base,
  output logic [opu_pkg::OPU_DELTA_BITS-1:0] step,
  output opu_pkg::op_t                       op
);
  import opu_pkg::*;

  logic [PRICE_BITS-1:0]     a;
  logic [OPU_DELTA_BITS-1:0] d;
  op_t                       o;
  logic [PRICE_BITS-1:0]     floor_mid;

  // remainder never exceeds the half sum, so it fits the price width
  assign floor_mid = half - PRICE_BITS'(rem);

  always_comb begin
    a = bid;
    d = '0;
    o = OP_PASS;
    case (urg_t'(urg))
      URG_MAKER: begin
        a = side ? ask : bid;
        d = delta;
        o = side ? OP_ADD : OP_SUB;
      end
      URG_MAKER_ONE: begin
        if (one_tick) begin
          a = side ? bid : ask;
        end else begin
          a = side ? ask : bid;
          d = OPU_DELTA_BITS'(tick);
          o = side ? OP_SUB : OP_ADD;
        end
      end
      URG_MIDPOINT: begin
        if (one_tick) begin
          a = side ? bid : ask;
        end else begin
          // round up to a tick for an ask when not exact
          a = floor_mid;
          d = (side && (rem != '0 || odd)) ? OPU_DELTA_BITS'(tick) : '0;
          o = OP_ADD;
        end
      end
      URG_TAKER: begin
        a = side ? bid : ask;
        d = delta;
        o = side ? OP_SUB : OP_ADD;
      end
      default: begin
        a = bid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base <= a;
      step <= d;
      op   <= o;
    end
  end

endmodule

// ===== rtl/opu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opu_back
// Saturating add or subtract, or pass of the base, into the output register.
// ----------------------------------------------------------------------------
module opu_back #(
  parameter int PRICE_BITS = opu_pkg::OPU_PRICE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               v_i,
  input  logic [PRICE_BITS-1:0]              base,
  input  logic [opu_pkg::OPU_DELTA_BITS-1:0] step,
  input  opu_pkg::op_t                       op,
  opu_result_if.source                       result
);
  import opu_pkg::*;

  localparam int W = ((PRICE_BITS > OPU_DELTA_BITS) ? PRICE_BITS : OPU_DELTA_BITS) + 1;

  logic [W-1:0]          sum;
  logic [W-1:0]          pmax;
  logic [PRICE_BITS-1:0] p;
  logic                  f;
  logic                  out_v;
  logic [PRICE_BITS-1:0] out_p;
  logic                  out_f;

  assign pmax = W'({PRICE_BITS{1'b1}});

  always_comb begin
    sum = '0;
    p   = base;
    f   = 1'b0;
    case (op)
      OP_ADD: begin
        sum = W'(base) + W'(step);
        if (sum > pmax) begin
          p = '1;
          f = 1'b1;
        end else begin
          p = sum[PRICE_BITS-1:0];
        end
      end
      OP_SUB: begin
        sum = W'(base) - W'(step);
        if (W'(step) > W'(base)) begin
          p = '0;
          f = 1'b1;
        end else begin
          p = sum[PRICE_BITS-1:0];
        end
      end
      default: begin
        p = base;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_p <= p;
      out_f <= f;
    end
  end

  assign result.valid      = out_v;
  assign result.price      = out_p;
  assign result.range_flag = out_f;

endmodule

// ===== rtl/order_price_by_urgency.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_price_by_urgency
// Order price from best quotes, side, urgency mode and tick offset.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  quote    in   valid/ready    bid_price, ask_price, side, urgency, tick_offset
//  result   out  valid/ready    price, range_flag
//  cfg      in   valid/ready    tick_size (ready always high)
//
//  One request per cycle unless the output stalls; the remainder chain resolves
//  four bits of the half sum per stage.
//  Synchronous reset clears all stage valid bits and sets tick_size to 1.
//  The whole pipeline holds while a result waits and result.ready is low.
// ----------------------------------------------------------------------------
module order_price_by_urgency #(
  parameter int PRICE_BITS = opu_pkg::OPU_PRICE_BITS
) (
  input  logic         clk,
  input  logic         rst,
  opu_quote_if.sink    quote,
  opu_result_if.source result,
  opu_cfg_if.sink      cfg
);
  import opu_pkg::*;

  localparam int NS = (PRICE_BITS + OPU_DIV_STEP - 1) / OPU_DIV_STEP;
  localparam int HW = NS * OPU_DIV_STEP;

  logic en;

  logic                      dv    [NS+1];
  logic [HW-1:0]             dhalf [NS+1];
  logic [OPU_TICK_BITS-1:0]  drem  [NS+1];
  logic [PRICE_BITS-1:0]     cbid  [NS+1];
  logic [PRICE_BITS-1:0]     cask  [NS+1];
  logic                      cside [NS+1];
  logic [1:0]                curg  [NS+1];
  logic [OPU_TICK_BITS-1:0]  ctick [NS+1];
  logic [OPU_DELTA_BITS-1:0] cdelta[NS+1];
  logic                      codd  [NS+1];
  logic                      cone  [NS+1];

  logic                      s_v;
  logic [PRICE_BITS-1:0]     s_base;
  logic [OPU_DELTA_BITS-1:0] s_step;
  op_t                       s_op;

  // global advance: move when the output is empty or being taken
  assign en = !result.valid || result.ready;

  opu_front #(.PRICE_BITS(PRICE_BITS), .HW(HW)) u_front (
    .clk(clk), .rst(rst), .en(en), .quote(quote), .cfg(cfg),
    .v(dv[0]), .bid(cbid[0]), .ask(cask[0]), .side(cside[0]), .urg(curg[0]),
    .tick(ctick[0]), .delta(cdelta[0]), .half(dhalf[0]), .odd(codd[0]),
    .one_tick(cone[0])
  );

  assign drem[0] = '0;

  // remainder chain with side fields carried alongside
  for (genvar k = 0; k < NS; k++) begin : g_div
    opu_div_stage #(.HW(HW), .LEVEL(k)) u_stage (
      .clk(clk), .rst(rst), .en(en), .v_i(dv[k]), .half_i(dhalf[k]),
      .tick(ctick[k]), .rem_i(drem[k]),
      .v_o(dv[k+1]), .half_o(dhalf[k+1]), .rem_o(drem[k+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        cbid[k+1]   <= cbid[k];
        cask[k+1]   <= cask[k];
        cside[k+1]  <= cside[k];
        curg[k+1]   <= curg[k];
        ctick[k+1]  <= ctick[k];
        cdelta[k+1] <= cdelta[k];
        codd[k+1]   <= codd[k];
        cone[k+1]   <= cone[k];
      end
    end
  end

  opu_select #(.PRICE_BITS(PRICE_BITS)) u_select (
    .clk(clk), .rst(rst), .en(en), .v_i(dv[NS]),
    .bid(cbid[NS]), .ask(cask[NS]), .side(cside[NS]), .urg(curg[NS]),
    .tick(ctick[NS]), .delta(cdelta[NS]), .half(dhalf[NS][PRICE_BITS-1:0]),
    .odd(codd[NS]), .one_tick(cone[NS]), .rem(drem[NS]),
    .v_o(s_v), .base(s_base), .step(s_step), .op(s_op)
  );

  opu_back #(.PRICE_BITS(PRICE_BITS)) u_back (
    .clk(clk), .rst(rst), .en(en), .v_i(s_v), .base(s_base), .step(s_step),
    .op(s_op), .result(result)
  );

endmodule

// ===== rtl/opu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opu_checker
// Port level checks for order_price_by_urgency, bound to the top level.
// ----------------------------------------------------------------------------
module opu_checker #(
  parameter int PRICE_BITS = opu_pkg::OPU_PRICE_BITS
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  quote_ready,
  input logic                  result_valid,
  input logic                  result_ready,
  input logic [PRICE_BITS-1:0] result_price,
  input logic                  result_flag,
  input logic                  cfg_ready
);

  // request taken exactly when the output side can move
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    quote_ready == (!result_valid || result_ready))
    else $error("quote ready does not follow output stall");

  // stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_price)
      && $stable(result_flag))
    else $error("stalled result changed");

  // a saturated price sits at a bound
  a_flag_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_flag |->
      result_price == '0 || result_price == {PRICE_BITS{1'b1}})
    else $error("range flag with price not at a bound");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("tick size write refused");

endmodule

bind order_price_by_urgency opu_checker #(.PRICE_BITS(PRICE_BITS)) u_opu_checker (
  .clk(clk), .rst(rst), .quote_ready(quote.ready), .result_valid(result.valid),
  .result_ready(result.ready), .result_price(result.price),
  .result_flag(result.range_flag), .cfg_ready(cfg.ready)
);
